// File: src/skyra_pkg.sv
// ----------------------------------------------------------------------------
// Skyline allocator package
// Shared types and codes for the skyline rectangle allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package skyra_pkg;

    localparam int unsigned OPCODE_W = 1;
    localparam int unsigned RECT_W_W = 7;
    localparam int unsigned RECT_H_W = 8;
    localparam int unsigned POS_W    = 7;

    localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WINDOW,
        ST_SCAN,
        ST_FINISH
    } skyra_state_t;

    // per-cycle command broadcast along the column chain
    typedef struct packed {
        logic load;    // copy fill into shadow, zero window max
        logic window;  // fold shadow into window max, shift shadow left
        logic scan;    // shift window max towards column 0
        logic commit;  // raise the columns inside the placed span
        logic clear;   // empty the skyline
    } skyra_cell_ctrl_t;

endpackage

`default_nettype wire

// File: src/skyline_rect_allocator_unit.sv
// ----------------------------------------------------------------------------
// Skyline rectangle allocator
// Bottom-left skyline packing of rectangles into a fixed atlas.
// ----------------------------------------------------------------------------
// The skyline lives in a row of ATLAS_WIDTH column cells. For an allocate
// transaction of width w, acceptance loads each cell's shadow copy, the window
// state shifts the shadows left so every cell builds the maximum fill of the
// w-wide window that starts at its column, the scan state shifts those window
// maxima to column 0 where one comparator keeps the earliest lowest start, and
// the finish state raises the covered columns and registers the result once
// the output register is free. Clear transactions and refused requests (zero
// width or height, width not below ATLAS_WIDTH) go from acceptance straight
// to the finish state. One transaction is worked on at a time; in_ready
// returns high as soon as the result sits in the output register, so the
// next transaction may be taken while that result waits for out_ready.
// After reset every column is empty.
`default_nettype none

module skyline_rect_allocator_unit
    import skyra_pkg::*;
#(
    parameter int unsigned ATLAS_WIDTH  = 128,
    parameter int unsigned ATLAS_HEIGHT = 128
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [OPCODE_W-1:0] opcode,
    input  wire logic [RECT_W_W-1:0] rect_width,
    input  wire logic [RECT_H_W-1:0] rect_height,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     granted,
    output logic [POS_W-1:0]         pos_x,
    output logic [POS_W-1:0]         pos_y
);

    // column index, counter and height widths
    localparam int unsigned XW     = (ATLAS_WIDTH > 1) ? $clog2(ATLAS_WIDTH) : 1;
    localparam int unsigned CW     = (XW + 1 > RECT_W_W + 1) ? XW + 1 : RECT_W_W + 1;
    localparam int unsigned FILL_W = $clog2(ATLAS_HEIGHT + 1);
    localparam int unsigned SUM_W  = ((FILL_W > RECT_H_W) ? FILL_W : RECT_H_W) + 1;

    localparam logic [CW-1:0]     ATLAS_W_C = CW'(ATLAS_WIDTH);
    localparam logic [FILL_W-1:0] ATLAS_H_F = FILL_W'(ATLAS_HEIGHT);
    localparam logic [SUM_W-1:0]  ATLAS_H_S = SUM_W'(ATLAS_HEIGHT);

    skyra_state_t        state_reg, state_next;
    logic                op_clear_reg, op_clear_next;
    logic                bad_reg, bad_next;
    logic [CW-1:0]       w_reg, w_next;
    logic [RECT_H_W-1:0] h_reg, h_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [FILL_W-1:0]   best_reg, best_next;
    logic [XW-1:0]       bx_reg, bx_next;
    logic                found_reg, found_next;

    logic                out_valid_reg, out_valid_next;
    logic                granted_reg, granted_next;
    logic [POS_W-1:0]    pos_x_reg, pos_x_next;
    logic [POS_W-1:0]    pos_y_reg, pos_y_next;

    skyra_cell_ctrl_t    ctrl;
    logic                in_take;
    logic                finish_go;
    logic                window_last;
    logic                scan_last;
    logic                fits;
    logic [CW-1:0]       w_in;
    logic [SUM_W-1:0]    top_sum;
    logic [FILL_W-1:0]   fill_new;
    logic [CW-1:0]       span_lo;
    logic [CW-1:0]       span_hi;

    logic [FILL_W-1:0]   shadow_q [ATLAS_WIDTH];
    logic [FILL_W-1:0]   acc_q    [ATLAS_WIDTH];

    // ---------------------------------------------------------------- decode
    assign w_in        = CW'(rect_width);
    assign in_take     = in_valid && in_ready;
    assign finish_go   = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);
    assign window_last = (cnt_reg == w_reg - CW'(1));
    assign scan_last   = (cnt_reg == ATLAS_W_C - w_reg - CW'(1));

    // placement check: lowest window plus the request must stay in the atlas
    assign top_sum  = SUM_W'(best_reg) + SUM_W'(h_reg);
    assign fits     = !bad_reg && found_reg && (top_sum <= ATLAS_H_S);
    assign fill_new = FILL_W'(top_sum);
    assign span_lo  = CW'(bx_reg);
    assign span_hi  = CW'(bx_reg) + w_reg;

    // ------------------------------------------------------------ next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if ((opcode == OP_CLEAR) || (rect_width == '0) ||
                        (rect_height == '0) || (w_in >= ATLAS_W_C))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_WINDOW;
                    end
                end
            end
            ST_WINDOW:
            begin
                if (window_last)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (finish_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------ control outputs
    always_comb
    begin
        in_ready    = 1'b0;
        ctrl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                ctrl.load = in_valid;
            end
            ST_WINDOW:
            begin
                ctrl.window = 1'b1;
            end
            ST_SCAN:
            begin
                ctrl.scan = 1'b1;
            end
            ST_FINISH:
            begin
                ctrl.clear  = finish_go && op_clear_reg;
                ctrl.commit = finish_go && !op_clear_reg && fits;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------- datapath
    always_comb
    begin
        op_clear_next  = op_clear_reg;
        bad_next       = bad_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        cnt_next       = cnt_reg;
        best_next      = best_reg;
        bx_next        = bx_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg && !out_ready;
        granted_next   = granted_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;

        if (in_take)
        begin
            op_clear_next = (opcode == OP_CLEAR);
            bad_next      = (rect_width == '0) || (rect_height == '0) ||
                            (w_in >= ATLAS_W_C);
            w_next        = w_in;
            h_next        = rect_height;
            cnt_next      = '0;
            best_next     = ATLAS_H_F;
            bx_next       = '0;
            found_next    = 1'b0;
        end

        if (state_reg == ST_WINDOW)
        begin
            cnt_next = window_last ? '0 : cnt_reg + CW'(1);
        end

        // window maxima arrive at column 0 in start-column order
        if (state_reg == ST_SCAN)
        begin
            cnt_next = cnt_reg + CW'(1);
            if (acc_q[0] < best_reg)
            begin
                best_next  = acc_q[0];
                bx_next    = cnt_reg[XW-1:0];
                found_next = 1'b1;
            end
        end

        if (finish_go)
        begin
            out_valid_next = 1'b1;
            granted_next   = op_clear_reg || fits;
            pos_x_next     = (!op_clear_reg && fits) ? POS_W'(bx_reg)   : '0;
            pos_y_next     = (!op_clear_reg && fits) ? POS_W'(best_reg) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_clear_reg <= op_clear_next;
        bad_reg      <= bad_next;
        w_reg        <= w_next;
        h_reg        <= h_next;
        cnt_reg      <= cnt_next;
        best_reg     <= best_next;
        bx_reg       <= bx_next;
        found_reg    <= found_next;
        granted_reg  <= granted_next;
        pos_x_reg    <= pos_x_next;
        pos_y_reg    <= pos_y_next;
    end

    assign out_valid = out_valid_reg;
    assign granted   = granted_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;

    // ---------------------------------------------------------- column chain
    // each cell takes its right neighbour's shadow and window max; the last
    // cell is padded with zero, which never reaches a start column in range
    for (genvar c = 0; c < ATLAS_WIDTH; c++)
    begin : g_col
        logic [FILL_W-1:0] shadow_from_right;
        logic [FILL_W-1:0] acc_from_right;

        if (c == ATLAS_WIDTH - 1)
        begin : g_tail
            assign shadow_from_right = '0;
            assign acc_from_right    = '0;
        end
        else
        begin : g_link
            assign shadow_from_right = shadow_q[c+1];
            assign acc_from_right    = acc_q[c+1];
        end

        skyra_cell #(
            .FILL_W  (FILL_W),
            .IDX_W   (CW),
            .COL_IDX (c)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .shadow_in  (shadow_from_right),
            .acc_in     (acc_from_right),
            .fill_new   (fill_new),
            .span_lo    (span_lo),
            .span_hi    (span_hi),
            .shadow_out (shadow_q[c]),
            .acc_out    (acc_q[c])
        );
    end

endmodule

`default_nettype wire

// File: src/skyra_cell.sv
// ----------------------------------------------------------------------------
// Skyline column cell
// Holds one column fill height plus the shifting shadow and window-max terms.
// ----------------------------------------------------------------------------
`default_nettype none

module skyra_cell
    import skyra_pkg::*;
#(
    parameter int unsigned FILL_W  = 8,
    parameter int unsigned IDX_W   = 8,
    parameter int unsigned COL_IDX = 0
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire skyra_cell_ctrl_t  ctrl,
    input  wire logic [FILL_W-1:0] shadow_in,
    input  wire logic [FILL_W-1:0] acc_in,
    input  wire logic [FILL_W-1:0] fill_new,
    input  wire logic [IDX_W-1:0]  span_lo,
    input  wire logic [IDX_W-1:0]  span_hi,
    output logic      [FILL_W-1:0] shadow_out,
    output logic      [FILL_W-1:0] acc_out
);

    localparam logic [IDX_W-1:0] COL = IDX_W'(COL_IDX);

    logic [FILL_W-1:0] fill_reg,   fill_next;
    logic [FILL_W-1:0] shadow_reg, shadow_next;
    logic [FILL_W-1:0] acc_reg,    acc_next;
    logic              in_span;

    assign in_span = (COL >= span_lo) && (COL < span_hi);

    always_comb
    begin
        fill_next   = fill_reg;
        shadow_next = shadow_reg;
        acc_next    = acc_reg;
        if (ctrl.clear)
        begin
            fill_next = '0;
        end
        else if (ctrl.commit && in_span)
        begin
            fill_next = fill_new;
        end
        if (ctrl.load)
        begin
            shadow_next = fill_reg;
            acc_next    = '0;
        end
        else if (ctrl.window)
        begin
            shadow_next = shadow_in;
            acc_next    = (shadow_reg > acc_reg) ? shadow_reg : acc_reg;
        end
        else if (ctrl.scan)
        begin
            acc_next = acc_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shadow_reg <= shadow_next;
        acc_reg    <= acc_next;
    end

    assign shadow_out = shadow_reg;
    assign acc_out    = acc_reg;

endmodule

`default_nettype wire

// File: src/skyra_checker.sv
// ----------------------------------------------------------------------------
// Skyline allocator checker
// Port-level properties of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module skyra_checker
    import skyra_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_ready,
    input  wire logic [OPCODE_W-1:0] opcode,
    input  wire logic                out_valid,
    input  wire logic                out_ready,
    input  wire logic                granted,
    input  wire logic [POS_W-1:0]    pos_x,
    input  wire logic [POS_W-1:0]    pos_y
);

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(granted) && $stable(pos_x) && $stable(pos_y))
        else $error("result changed while stalled");

    // a refusal carries a zero position
    a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !granted |-> (pos_x == '0) && (pos_y == '0))
        else $error("refused result with non-zero position");

    // one transaction in flight: ready drops after each acceptance
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction taken while busy");

    // a clear into an empty output yields a grant
    a_clear_grant: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (opcode == OP_CLEAR) && !out_valid |->
            ##2 out_valid && granted)
        else $error("clear did not report a grant");

endmodule

bind skyline_rect_allocator_unit skyra_checker u_skyra_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .granted   (granted),
    .pos_x     (pos_x),
    .pos_y     (pos_y)
);

`default_nettype wire
